>>> src/dcc_pkg.sv
`default_nettype none

package dcc_pkg;

  localparam int SAMPLE_BITS_DEF = 16;

  localparam int ZONE_W     = 8;
  localparam int CURVE_W    = 8;
  localparam int CFG_DATA_W = 8;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_LEFT_ZONE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_ZONE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_ZONE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CURVE       = 2'd3;

  // span divisor 1000 - C - 2L (or 2R) stays in 235..1000
  localparam int SPAN_DIV_W = 10;

  localparam int                   HUNDRED_W = 7;
  localparam logic [HUNDRED_W-1:0] HUNDRED   = 7'd100;

  typedef logic [2:0] span_t;
  localparam span_t SPAN_LO_END = 3'd0;
  localparam span_t SPAN_LEFT   = 3'd1;
  localparam span_t SPAN_DEAD   = 3'd2;
  localparam span_t SPAN_RIGHT  = 3'd3;
  localparam span_t SPAN_HI_END = 3'd4;

  typedef logic [1:0] sat_t;
  localparam sat_t SAT_NONE = 2'd0;
  localparam sat_t SAT_LO   = 2'd1;
  localparam sat_t SAT_HI   = 2'd2;

endpackage

`default_nettype wire

>>> src/axis_deadzone_cubic_curve_top.sv
`default_nettype none

// Joystick axis shaper: end zones, center dead zone and cubic response curve.
// Input channel in_valid/in_stall/in_axis_in carries one Q1.(SAMPLE_BITS-1)
// sample per word; output channel out_valid/out_stall/out_axis_out carries the
// shaped sample. A word moves when valid is high and stall is low.
// The four zone/curve registers are written through cfg_wr_en, cfg_index and
// cfg_data; the user must write them only while no word is in flight, which
// the block itself does not enforce. They reset to zero (linear, no zones). The
// pipelined span divider resolves one quotient bit per stage; the divide by 100
// of the blend is a two-stage reciprocal multiply. Throughput is one word per
// clock while in_stall is low. Reset clears all valid bits and the configuration
// registers. When the receiver stalls, the output word holds; one more word may
// drop into a skid register, and then in_stall rises and the whole pipeline holds
// until the receiver takes the output word. No word is lost or repeated.
module axis_deadzone_cubic_curve_top #(
  parameter int SAMPLE_BITS = dcc_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0]        in_axis_in,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [SAMPLE_BITS-1:0]             out_axis_out,
  input  wire logic                                 cfg_wr_en,
  input  wire logic [dcc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [dcc_pkg::CFG_DATA_W-1:0]       cfg_data
);

  import dcc_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int FB = SB - 1;
  localparam logic [SB-1:0] F_U = SB'(1) << FB;

  logic [ZONE_W-1:0]         left_zone_r;
  logic [ZONE_W-1:0]         center_zone_r;
  logic [ZONE_W-1:0]         right_zone_r;
  logic signed [CURVE_W-1:0] curve_r;

  logic en;

  logic                        sp_valid;
  logic [FB+SPAN_DIV_W-1:0]    sp_num;
  logic [SPAN_DIV_W-1:0]       sp_den;
  span_t                       sp_span;

  logic                        d1_valid;
  logic [FB-1:0]               d1_quo;
  span_t                       d1_span;

  logic                        sh_valid;
  logic [SB-1:0]               sh_quo;
  sat_t                        sh_sat;

  logic signed [SB-1:0] y;

  logic                 out_valid_r, out_valid_nxt;
  logic signed [SB-1:0] out_axis_r, out_axis_nxt;
  logic                 skid_valid_r, skid_valid_nxt;
  logic signed [SB-1:0] skid_axis_r, skid_axis_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_zone_r   <= '0;
      center_zone_r <= '0;
      right_zone_r  <= '0;
      curve_r       <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_LEFT_ZONE:   left_zone_r   <= cfg_data;
        REG_CENTER_ZONE: center_zone_r <= cfg_data;
        REG_RIGHT_ZONE:  right_zone_r  <= cfg_data;
        REG_CURVE:       curve_r       <= cfg_data;
        default: ;
      endcase
    end
  end

  // the whole pipeline advances unless the skid register holds a word
  assign en       = !skid_valid_r;
  assign in_stall = skid_valid_r;

  dcc_span #(
    .SAMPLE_BITS(SB)
  ) u_span (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (in_valid),
    .in_axis    (in_axis_in),
    .left_zone  (left_zone_r),
    .center_zone(center_zone_r),
    .right_zone (right_zone_r),
    .out_valid  (sp_valid),
    .out_num    (sp_num),
    .out_den    (sp_den),
    .out_span   (sp_span)
  );

  dcc_div #(
    .Q_BITS(FB),
    .D_BITS(SPAN_DIV_W),
    .TAG_W ($bits(span_t))
  ) u_span_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (sp_valid),
    .in_num   (sp_num),
    .in_den   (sp_den),
    .in_tag   (sp_span),
    .out_valid(d1_valid),
    .out_quo  (d1_quo),
    .out_tag  (d1_span)
  );

  dcc_shape #(
    .SAMPLE_BITS(SB)
  ) u_shape (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (d1_valid),
    .in_quo   (d1_quo),
    .in_span  (d1_span),
    .curve    (curve_r),
    .out_valid(sh_valid),
    .out_quo  (sh_quo),
    .out_sat  (sh_sat)
  );

  // quotient carries an offset of +1.0; drop it
  always_comb begin
    case (sh_sat)
      SAT_LO:  y = {1'b1, {FB{1'b0}}};
      SAT_HI:  y = {1'b0, {FB{1'b1}}};
      default: y = sh_quo - F_U;
    endcase
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_axis_nxt   = out_axis_r;
    skid_valid_nxt = skid_valid_r;
    skid_axis_nxt  = skid_axis_r;
    if (skid_valid_r) begin
      if (!out_stall) begin
        out_axis_nxt   = skid_axis_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (sh_valid) begin
      if (out_valid_r && out_stall) begin
        skid_valid_nxt = 1'b1;
        skid_axis_nxt  = y;
      end else begin
        out_valid_nxt = 1'b1;
        out_axis_nxt  = y;
      end
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_axis_r  <= out_axis_nxt;
    skid_axis_r <= skid_axis_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_axis_out = out_axis_r;

  a_skid_behind_output: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a word while the output register is empty");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && out_stall))
    else $error("skid register filled without a stalled output word");

  a_skid_drain_keeps_output: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |=> out_valid_r)
    else $error("output went empty while the skid register held a word");

endmodule

`default_nettype wire

>>> src/dcc_div.sv
`default_nettype none

// Restoring unsigned divider, one quotient bit per pipeline stage.
// Expects in_num < in_den * 2**Q_BITS.
module dcc_div #(
  parameter int Q_BITS = 15,
  parameter int D_BITS = 10,
  parameter int TAG_W  = 3
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       en,
  input  wire logic                       in_valid,
  input  wire logic [Q_BITS+D_BITS-1:0]   in_num,
  input  wire logic [D_BITS-1:0]          in_den,
  input  wire logic [TAG_W-1:0]           in_tag,
  output logic                            out_valid,
  output logic [Q_BITS-1:0]               out_quo,
  output logic [TAG_W-1:0]                out_tag
);

  localparam int NW = Q_BITS + D_BITS;

  logic              valid_r [Q_BITS];
  logic [Q_BITS-1:0] quo_r   [Q_BITS];
  logic [TAG_W-1:0]  tag_r   [Q_BITS];
  logic [NW-1:0]     rem_r   [Q_BITS-1];
  logic [D_BITS-1:0] den_r   [Q_BITS-1];

  for (genvar k = 0; k < Q_BITS; k++) begin : g_stage
    localparam int SH = Q_BITS - 1 - k;

    logic              v_in;
    logic [NW-1:0]     rem_in;
    logic [D_BITS-1:0] den_in;
    logic [Q_BITS-1:0] quo_in;
    logic [TAG_W-1:0]  tag_in;
    logic [NW-1:0]     den_sh;
    logic              fits;
    logic [Q_BITS-1:0] quo_nxt;

    if (k == 0) begin : g_head
      assign v_in   = in_valid;
      assign rem_in = in_num;
      assign den_in = in_den;
      assign quo_in = '0;
      assign tag_in = in_tag;
    end else begin : g_body
      assign v_in   = valid_r[k-1];
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign quo_in = quo_r[k-1];
      assign tag_in = tag_r[k-1];
    end

    assign den_sh  = NW'(den_in) << SH;
    assign fits    = rem_in >= den_sh;
    assign quo_nxt = {quo_in[Q_BITS-2:0], fits};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (en) begin
        valid_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[k] <= quo_nxt;
        tag_r[k] <= tag_in;
      end
    end

    if (k < Q_BITS - 1) begin : g_keep
      logic [NW-1:0] rem_nxt;

      assign rem_nxt = fits ? (rem_in - den_sh) : rem_in;

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= rem_nxt;
          den_r[k] <= den_in;
        end
      end
    end
  end

  assign out_valid = valid_r[Q_BITS-1];
  assign out_quo   = quo_r[Q_BITS-1];
  assign out_tag   = tag_r[Q_BITS-1];

endmodule

`default_nettype wire

>>> src/dcc_span.sv
`default_nettype none

// Span classification: register the sample, scale by 1000, pick the span and
// build a non-negative numerator and divisor for the live spans.
module dcc_span #(
  parameter int SAMPLE_BITS = dcc_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire logic                                      en,
  input  wire logic                                      in_valid,
  input  wire logic signed [SAMPLE_BITS-1:0]             in_axis,
  input  wire logic [dcc_pkg::ZONE_W-1:0]                left_zone,
  input  wire logic [dcc_pkg::ZONE_W-1:0]                center_zone,
  input  wire logic [dcc_pkg::ZONE_W-1:0]                right_zone,
  output logic                                           out_valid,
  output logic [SAMPLE_BITS-2+dcc_pkg::SPAN_DIV_W:0]     out_num,
  output logic [dcc_pkg::SPAN_DIV_W-1:0]                 out_den,
  output dcc_pkg::span_t                                 out_span
);

  import dcc_pkg::*;

  localparam int FB  = SAMPLE_BITS - 1;
  localparam int XW  = SAMPLE_BITS + 10;
  localparam int NW  = FB + SPAN_DIV_W;
  localparam int DW1 = SPAN_DIV_W + 1;

  logic                          valid_a_r;
  logic signed [SAMPLE_BITS-1:0] x_a_r;
  logic                          valid_b_r;
  logic signed [XW-1:0]          xs_b_r;
  logic                          valid_c_r;
  logic [NW-1:0]                 num_c_r;
  logic [SPAN_DIV_W-1:0]         den_c_r;
  span_t                         span_c_r;

  logic signed [XW-1:0] x_ext;
  logic signed [XW-1:0] xs_nxt;
  logic signed [XW-1:0] l_ext, c_ext, r_ext;
  logic signed [XW-1:0] thr_lo, thr_cn, thr_hi;
  logic signed [XW-1:0] num_left, num_right;
  logic [DW1-1:0]       den_l_w, den_r_w;
  logic [NW-1:0]        num_nxt;
  logic [SPAN_DIV_W-1:0] den_nxt;
  span_t                span_nxt;

  // 1000 * x as 1024x - 16x - 8x
  assign x_ext  = XW'(x_a_r);
  assign xs_nxt = (x_ext <<< 10) - (x_ext <<< 4) - (x_ext <<< 3);

  assign l_ext = XW'(left_zone);
  assign c_ext = XW'(center_zone);
  assign r_ext = XW'(right_zone);

  assign thr_lo = ((l_ext <<< 1) - XW'(1000)) <<< FB;
  assign thr_cn = c_ext <<< FB;
  assign thr_hi = (XW'(1000) - (r_ext <<< 1)) <<< FB;

  // left numerator is shifted up by den*F so the quotient comes out as t + F
  assign num_left  = xs_b_r - thr_lo;
  assign num_right = xs_b_r - thr_cn;

  assign den_l_w = DW1'(1000) - DW1'(center_zone) - (DW1'(left_zone) << 1);
  assign den_r_w = DW1'(1000) - DW1'(center_zone) - (DW1'(right_zone) << 1);

  always_comb begin
    num_nxt = '0;
    den_nxt = den_r_w[SPAN_DIV_W-1:0];
    if (xs_b_r < thr_lo) begin
      span_nxt = SPAN_LO_END;
    end else if (xs_b_r < -thr_cn) begin
      span_nxt = SPAN_LEFT;
      num_nxt  = num_left[NW-1:0];
      den_nxt  = den_l_w[SPAN_DIV_W-1:0];
    end else if (xs_b_r < thr_cn) begin
      span_nxt = SPAN_DEAD;
    end else if (xs_b_r < thr_hi) begin
      span_nxt = SPAN_RIGHT;
      num_nxt  = num_right[NW-1:0];
    end else begin
      span_nxt = SPAN_HI_END;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
      valid_b_r <= 1'b0;
      valid_c_r <= 1'b0;
    end else if (en) begin
      valid_a_r <= in_valid;
      valid_b_r <= valid_a_r;
      valid_c_r <= valid_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_a_r    <= in_axis;
      xs_b_r   <= xs_nxt;
      num_c_r  <= num_nxt;
      den_c_r  <= den_nxt;
      span_c_r <= span_nxt;
    end
  end

  assign out_valid = valid_c_r;
  assign out_num   = num_c_r;
  assign out_den   = den_c_r;
  assign out_span  = span_c_r;

endmodule

`default_nettype wire

>>> src/dcc_shape.sv
`default_nettype none

// Curve shaping: recover t, cube it, blend with the linear term, clamp, then
// divide the non-negative blend by 100 with a two-stage reciprocal multiply.
module dcc_shape #(
  parameter int SAMPLE_BITS = dcc_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    en,
  input  wire logic                                    in_valid,
  input  wire logic [SAMPLE_BITS-2:0]                  in_quo,
  input  wire dcc_pkg::span_t                          in_span,
  input  wire logic signed [dcc_pkg::CURVE_W-1:0]      curve,
  output logic                                         out_valid,
  output logic [SAMPLE_BITS-1:0]                       out_quo,
  output dcc_pkg::sat_t                                out_sat
);

  import dcc_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int FB = SB - 1;
  localparam int PW = SB + 10;
  localparam int N2 = SB + HUNDRED_W;
  localparam logic [SB-1:0]        F_U = SB'(1) << FB;
  localparam logic signed [PW-1:0] LIM = PW'(100) <<< FB;

  // 1/100 rounded up; exact for every numerator below 2**N2
  localparam int QS   = N2 + HUNDRED_W;
  localparam int MW   = N2 + 1;
  localparam int LO_W = MW / 2;
  localparam int HI_W = MW - LO_W;
  localparam int PW2  = N2 + MW;
  localparam logic [63:0]     RECIP_64 =
    ((64'd1 << QS) + 64'(HUNDRED) - 64'd1) / 64'(HUNDRED);
  localparam logic [MW-1:0]   RECIP    = RECIP_64[MW-1:0];
  localparam logic [LO_W-1:0] RECIP_LO = RECIP[LO_W-1:0];
  localparam logic [HI_W-1:0] RECIP_HI = RECIP[MW-1:LO_W];

  // stage 1
  logic                 valid1_r;
  logic signed [SB-1:0] t1_r;
  logic [SB-1:0]        a1_r;
  logic                 neg1_r;
  sat_t                 sat1_r;
  logic signed [SB-1:0] t1_nxt;
  logic [SB-1:0]        a1_nxt;
  logic                 neg1_nxt;
  sat_t                 sat1_nxt;

  // stage 2
  logic                 valid2_r;
  logic signed [SB-1:0] t2_r;
  logic [SB-1:0]        a2_r;
  logic [SB-1:0]        a2a_r;
  logic                 neg2_r;
  sat_t                 sat2_r;
  logic [2*SB-1:0]      sq;

  // stage 3
  logic                 valid3_r;
  logic signed [SB-1:0] t3_r;
  logic [SB-1:0]        a3_r;
  logic                 neg3_r;
  sat_t                 sat3_r;
  logic [2*SB-1:0]      cb;

  // stage 4
  logic                 valid4_r;
  logic signed [PW-1:0] p1_r, p2_r;
  logic                 neg4_r;
  sat_t                 sat4_r;
  logic signed [PW-1:0] c_ext, k_ext, a3_ext, t_ext;

  // stage 5
  logic                 valid5_r;
  logic [N2-1:0]        num5_r;
  sat_t                 sat5_r;
  logic signed [PW-1:0] s_sum, s_off;
  sat_t                 sat5_nxt;

  // stage 6
  logic                 valid6_r;
  logic [N2+LO_W-1:0]   plo6_r;
  logic [N2+HI_W-1:0]   phi6_r;
  sat_t                 sat6_r;

  // stage 7
  logic                 valid7_r;
  logic [SB-1:0]        quo7_r;
  sat_t                 sat7_r;
  logic [PW2-1:0]       prod;

  always_comb begin
    t1_nxt   = '0;
    a1_nxt   = '0;
    neg1_nxt = 1'b0;
    sat1_nxt = SAT_NONE;
    case (in_span)
      SPAN_LEFT: begin
        t1_nxt   = {1'b1, in_quo};
        a1_nxt   = F_U - SB'(in_quo);
        neg1_nxt = 1'b1;
      end
      SPAN_RIGHT: begin
        t1_nxt = {1'b0, in_quo};
        a1_nxt = SB'(in_quo);
      end
      SPAN_LO_END: sat1_nxt = SAT_LO;
      SPAN_HI_END: sat1_nxt = SAT_HI;
      default: sat1_nxt = SAT_NONE;
    endcase
  end

  // truncate each square and cube on the magnitude
  assign sq = {{SB{1'b0}}, a1_r} * {{SB{1'b0}}, a1_r};
  assign cb = {{SB{1'b0}}, a2_r} * {{SB{1'b0}}, a2a_r};

  assign c_ext  = PW'(curve);
  assign k_ext  = PW'(100) - c_ext;
  assign a3_ext = PW'(a3_r);
  assign t_ext  = PW'(t3_r);

  assign s_sum = neg4_r ? (p2_r - p1_r) : (p2_r + p1_r);
  assign s_off = s_sum + LIM;

  always_comb begin
    sat5_nxt = sat4_r;
    if (sat4_r == SAT_NONE) begin
      if (s_sum < -LIM) begin
        sat5_nxt = SAT_LO;
      end else if (s_sum >= LIM) begin
        sat5_nxt = SAT_HI;
      end
    end
  end

  assign prod = (PW2'(phi6_r) << LO_W) + PW2'(plo6_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r <= 1'b0;
      valid2_r <= 1'b0;
      valid3_r <= 1'b0;
      valid4_r <= 1'b0;
      valid5_r <= 1'b0;
      valid6_r <= 1'b0;
      valid7_r <= 1'b0;
    end else if (en) begin
      valid1_r <= in_valid;
      valid2_r <= valid1_r;
      valid3_r <= valid2_r;
      valid4_r <= valid3_r;
      valid5_r <= valid4_r;
      valid6_r <= valid5_r;
      valid7_r <= valid6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r   <= t1_nxt;
      a1_r   <= a1_nxt;
      neg1_r <= neg1_nxt;
      sat1_r <= sat1_nxt;

      t2_r   <= t1_r;
      a2_r   <= sq[FB +: SB];
      a2a_r  <= a1_r;
      neg2_r <= neg1_r;
      sat2_r <= sat1_r;

      t3_r   <= t2_r;
      a3_r   <= cb[FB +: SB];
      neg3_r <= neg2_r;
      sat3_r <= sat2_r;

      p1_r   <= c_ext * a3_ext;
      p2_r   <= k_ext * t_ext;
      neg4_r <= neg3_r;
      sat4_r <= sat3_r;

      num5_r <= s_off[N2-1:0];
      sat5_r <= sat5_nxt;

      plo6_r <= {{LO_W{1'b0}}, num5_r} * {{N2{1'b0}}, RECIP_LO};
      phi6_r <= {{HI_W{1'b0}}, num5_r} * {{N2{1'b0}}, RECIP_HI};
      sat6_r <= sat5_r;

      quo7_r <= prod[QS +: SB];
      sat7_r <= sat6_r;
    end
  end

  assign out_valid = valid7_r;
  assign out_quo   = quo7_r;
  assign out_sat   = sat7_r;

endmodule

`default_nettype wire
